### rtl/core/dgr_pkg.sv
// shared types, constants and float helpers for the gather/dequant block
// no dependencies; every other rtl/core file imports this package
`default_nettype none
package dgr_pkg;

    localparam int STORE_BYTES   = 65536;
    localparam int GROUP_ENTRIES = 1024;
    localparam int MAX_ROW       = 64;

    localparam int BA_W  = $clog2(STORE_BYTES);
    localparam int GI_W  = $clog2(GROUP_ENTRIES);
    localparam int NUM_W = 41;
    localparam int AX_W  = 17;
    localparam int RL_W  = 7;
    localparam int EL_W  = 6;

    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_SCALE  = 2'd1;
    localparam logic [1:0] MODE_ZERO   = 2'd2;
    localparam logic [1:0] MODE_GATHER = 2'd3;

    localparam logic [1:0] FMT_U8 = 2'd0;
    localparam logic [1:0] FMT_I8 = 2'd1;
    localparam logic [1:0] FMT_U4 = 2'd2;
    localparam logic [1:0] FMT_I4 = 2'd3;

    localparam logic [2:0] CFG_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_HALF     = 3'd1;
    localparam logic [2:0] CFG_USE_ZP   = 3'd2;
    localparam logic [2:0] CFG_WRAP     = 3'd3;
    localparam logic [2:0] CFG_AXIS     = 3'd4;
    localparam logic [2:0] CFG_ROWLEN   = 3'd5;
    localparam logic [2:0] CFG_SGROUP   = 3'd6;
    localparam logic [2:0] CFG_ZGROUP   = 3'd7;

    localparam logic [31:0] F32_DNAN = 32'hFFC0_0000;
    localparam logic [31:0] F32_QBIT = 32'h0040_0000;
    localparam logic [30:0] F32_INF  = 31'h7F80_0000;

    typedef enum logic [1:0] {
        FOP_SUB = 2'b01,
        FOP_MUL = 2'b10
    } t_fop;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        ready;
        logic        done;
        logic [31:0] res;
    } t_fpu_st;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [AX_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic            ready;
        logic            done;
        logic [GI_W-1:0] quot;
        logic [AX_W-1:0] rem;
    } t_div_st;

    typedef struct packed {
        logic            data_we;
        logic            scale_we;
        logic            zero_we;
        logic [BA_W-1:0] addr;
        logic [31:0]     wdata;
    } t_st_wr;

    typedef struct packed {
        logic            re;
        logic [BA_W-1:0] byte_addr;
        logic [GI_W-1:0] s_idx;
        logic [GI_W-1:0] z_idx;
    } t_st_rd;

    function automatic logic [31:0] code_to_f32(input logic signed [8:0] c);
        logic       s;
        logic [7:0] mag;
        logic [7:0] nm;
        logic [2:0] lz;
        logic [7:0] ex;
        logic [31:0] r;
        s   = c[8];
        mag = 8'(s ? -c : c);
        lz  = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) lz = 3'(7 - i);
        end
        nm = mag << lz;
        ex = 8'd134 - {5'd0, lz};
        r  = (mag == 8'd0) ? 32'd0 : {s, ex, nm[6:0], 16'd0};
        return r;
    endfunction

    function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
        logic              s;
        logic [7:0]        ex;
        logic [22:0]       man;
        logic signed [9:0] e;
        logic [23:0]       full;
        logic [4:0]        sh;
        logic [23:0]       rem;
        logic [23:0]       halfw;
        logic [14:0]       h;
        logic [12:0]       rm;
        logic [15:0]       r;
        s   = x[31];
        ex  = x[30:23];
        man = x[22:0];
        e   = $signed({2'b00, ex}) - 10'sd112;
        r   = 16'd0;
        if (ex == 8'hFF) begin
            r = (man != 23'd0) ? {s, 15'h7E00 | {5'd0, man[22:13]}} : {s, 15'h7C00};
        end else if (e >= 10'sd31) begin
            r = {s, 15'h7C00};
        end else if (e <= 10'sd0) begin
            if (e < -10'sd10) begin
                r = {s, 15'd0};
            end else begin
                full  = {1'b1, man};
                sh    = 5'(10'sd14 - e);
                rem   = full & ((24'd1 << sh) - 24'd1);
                halfw = 24'd1 << (sh - 5'd1);
                h     = 15'(full >> sh);
                if (rem > halfw || (rem == halfw && h[0])) h = h + 15'd1;
                r = {s, h};
            end
        end else begin
            h  = {e[4:0], man[22:13]};
            rm = man[12:0];
            if (rm > 13'h1000 || (rm == 13'h1000 && h[0])) h = h + 15'd1;
            r = {s, h};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/dequant_gather_rows.sv
// Gather of one row from a quantized weight store with per-group dequantization.
// Write beats (data byte, scale, zero point) are taken while idle and leave o_in_stall low.
// A gather beat stalls the input until its row has been handed to the output register.
// An out-of-range row emits its n zero elements straight away. An in-range row first
// computes its element index, then runs two passes of the bit-serial divider to find
// the first scale and zero point group; each element then costs one store read and
// one subtract and one multiply in the shared float unit. Output stalls hold the
// emit state. The user must write config only while idle; the block does not enforce it.
`default_nettype none
module dequant_gather_rows (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_addr,
    input  logic [31:0] i_wdata,
    input  logic [15:0] i_outer_row,
    input  logic signed [31:0] i_gather_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_out_of_range,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import dgr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL1  = 12'b0000_0000_0010,
        S_MUL2  = 12'b0000_0000_0100,
        S_DIVS  = 12'b0000_0000_1000,
        S_WDIVS = 12'b0000_0001_0000,
        S_DIVZ  = 12'b0000_0010_0000,
        S_WDIVZ = 12'b0000_0100_0000,
        S_FETCH = 12'b0000_1000_0000,
        S_CONV  = 12'b0001_0000_0000,
        S_WSUB  = 12'b0010_0000_0000,
        S_WMUL  = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    t_state           r_state;
    logic [1:0]       r_fmt;
    logic             r_half;
    logic             r_use_zp;
    logic             r_wrap;
    logic [AX_W-1:0]  r_axis;
    logic [RL_W-1:0]  r_rowlen;
    logic [AX_W-1:0]  r_sg;
    logic [AX_W-1:0]  r_zg;

    logic [15:0]      r_orow;
    logic [AX_W-1:0]  r_idx;
    logic             r_oor;
    logic [EL_W-1:0]  r_nm1;
    logic [EL_W-1:0]  r_elem;
    logic [NUM_W-1:0] r_num;
    logic [GI_W-1:0]  r_qs;
    logic [GI_W-1:0]  r_qz;
    logic [AX_W-1:0]  r_rs;
    logic [AX_W-1:0]  r_rz;

    logic             r_out_valid;
    logic [31:0]      r_value;
    logic             r_out_oor;
    logic             r_last;

    logic             in_acc;
    logic             out_free;
    logic             emit_load;
    logic             last_elem;
    logic [AX_W-1:0]  sg_eff;
    logic [AX_W-1:0]  zg_eff;
    logic [RL_W-1:0]  n_eff;
    logic signed [32:0] idx_x;
    logic signed [32:0] idx_w;
    logic             idx_oor;
    logic [32:0]      p1;
    logic [33:0]      p_sum;
    logic [NUM_W-1:0] p2;
    logic [3:0]       nib;
    logic signed [8:0] code;
    logic [AX_W:0]    rs_inc;
    logic [AX_W:0]    rz_inc;
    logic [31:0]      emit_value;

    t_st_wr   st_wr;
    t_st_rd   st_rd;
    t_div_req div_req;
    t_div_st  div_st;
    t_fpu_req fpu_req;
    t_fpu_st  fpu_st;
    logic [7:0]  rd_byte;
    logic [31:0] rd_scale;
    logic [31:0] rd_zero;

    dgr_store u_store (
        .i_clk   (i_clk),
        .i_wr    (st_wr),
        .i_rd    (st_rd),
        .o_byte  (rd_byte),
        .o_scale (rd_scale),
        .o_zero  (rd_zero)
    );

    dgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_st    (div_st)
    );

    dgr_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_st    (fpu_st)
    );

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        in_acc     = i_in_valid && !o_in_stall;
        out_free   = !r_out_valid || !i_out_stall;
        emit_load  = (r_state == S_EMIT) && out_free;
        last_elem  = (r_elem == r_nm1);

        sg_eff = (r_sg == '0) ? AX_W'(1) : r_sg;
        zg_eff = (r_zg == '0) ? AX_W'(1) : r_zg;
        if (r_rowlen == '0)                  n_eff = RL_W'(1);
        else if (r_rowlen > RL_W'(MAX_ROW))  n_eff = RL_W'(MAX_ROW);
        else                                 n_eff = r_rowlen;

        idx_x   = {i_gather_index[31], i_gather_index};
        idx_w   = (idx_x[32] && r_wrap) ? idx_x + $signed({16'd0, r_axis}) : idx_x;
        idx_oor = idx_w[32] || ($unsigned(idx_w) >= {16'd0, r_axis});

        p1    = {17'd0, r_orow} * {16'd0, r_axis};
        p_sum = {1'b0, r_num[32:0]} + {17'd0, r_idx};
        p2    = {7'd0, p_sum} * {34'd0, n_eff};

        nib = r_num[0] ? rd_byte[7:4] : rd_byte[3:0];
        unique case (r_fmt)
            FMT_U8:  code = {1'b0, rd_byte};
            FMT_I8:  code = {rd_byte[7], rd_byte};
            FMT_U4:  code = {5'd0, nib};
            FMT_I4:  code = {{5{nib[3]}}, nib};
            default: code = '0;
        endcase

        rs_inc = {1'b0, r_rs} + 1'b1;
        rz_inc = {1'b0, r_rz} + 1'b1;

        st_wr.data_we  = in_acc && (i_mode == MODE_DATA);
        st_wr.scale_we = in_acc && (i_mode == MODE_SCALE);
        st_wr.zero_we  = in_acc && (i_mode == MODE_ZERO);
        st_wr.addr     = i_addr;
        st_wr.wdata    = i_wdata;

        st_rd.re        = (r_state == S_FETCH);
        st_rd.byte_addr = r_fmt[1] ? r_num[BA_W:1] : r_num[BA_W-1:0];
        st_rd.s_idx     = r_qs;
        st_rd.z_idx     = r_qz;

        div_req.start    = (r_state == S_DIVS) || (r_state == S_DIVZ);
        div_req.dividend = r_num;
        div_req.divisor  = (r_state == S_DIVS) ? sg_eff : zg_eff;

        fpu_req.start = (r_state == S_CONV) || ((r_state == S_WSUB) && fpu_st.done);
        fpu_req.op    = (r_state == S_CONV) ? FOP_SUB : FOP_MUL;
        fpu_req.a     = (r_state == S_CONV) ? code_to_f32(code) : fpu_st.res;
        fpu_req.b     = (r_state == S_CONV) ? (r_use_zp ? rd_zero : 32'd0) : rd_scale;

        if (r_oor)       emit_value = 32'd0;
        else if (r_half) emit_value = {16'd0, f32_to_f16(fpu_st.res)};
        else             emit_value = fpu_st.res;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_U8;
            r_half   <= 1'b0;
            r_use_zp <= 1'b0;
            r_wrap   <= 1'b0;
            r_axis   <= AX_W'(1);
            r_rowlen <= RL_W'(1);
            r_sg     <= AX_W'(1);
            r_zg     <= AX_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_fmt    <= i_cfg_data[1:0];
                CFG_HALF:   r_half   <= i_cfg_data[0];
                CFG_USE_ZP: r_use_zp <= i_cfg_data[0];
                CFG_WRAP:   r_wrap   <= i_cfg_data[0];
                CFG_AXIS:   r_axis   <= i_cfg_data;
                CFG_ROWLEN: r_rowlen <= i_cfg_data[RL_W-1:0];
                CFG_SGROUP: r_sg     <= i_cfg_data;
                CFG_ZGROUP: r_zg     <= i_cfg_data;
                default:    r_fmt    <= r_fmt;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_elem  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == MODE_GATHER)) begin
                        r_orow  <= i_outer_row;
                        r_idx   <= idx_w[AX_W-1:0];
                        r_oor   <= idx_oor;
                        r_nm1   <= EL_W'(n_eff - RL_W'(1));
                        r_elem  <= '0;
                        r_state <= idx_oor ? S_EMIT : S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_num   <= NUM_W'(p1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_num   <= p2;
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_WDIVS;
                S_WDIVS: begin
                    if (div_st.done) begin
                        r_qs    <= div_st.quot;
                        r_rs    <= div_st.rem;
                        r_state <= S_DIVZ;
                    end
                end
                S_DIVZ: r_state <= S_WDIVZ;
                S_WDIVZ: begin
                    if (div_st.done) begin
                        r_qz    <= div_st.quot;
                        r_rz    <= div_st.rem;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_CONV;
                S_CONV:  r_state <= S_WSUB;
                S_WSUB: begin
                    if (fpu_st.done) r_state <= S_WMUL;
                end
                S_WMUL: begin
                    if (fpu_st.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_elem <= r_elem + 1'b1;
                        r_num  <= r_num + 1'b1;
                        if (rs_inc == {1'b0, sg_eff}) begin
                            r_rs <= '0;
                            r_qs <= r_qs + 1'b1;
                        end else begin
                            r_rs <= rs_inc[AX_W-1:0];
                        end
                        if (rz_inc == {1'b0, zg_eff}) begin
                            r_rz <= '0;
                            r_qz <= r_qz + 1'b1;
                        end else begin
                            r_rz <= rz_inc[AX_W-1:0];
                        end
                        if (last_elem)  r_state <= S_IDLE;
                        else if (r_oor) r_state <= S_EMIT;
                        else            r_state <= S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
            r_value     <= emit_value;
            r_out_oor   <= r_oor;
            r_last      <= last_elem;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_out_of_range = r_out_oor;
    assign o_last         = r_last;

    a_fpu_start_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_req.start |-> fpu_st.ready)
        else $error("float unit started while busy");

    a_elem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_elem <= r_nm1))
        else $error("element count past row end");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && last_elem) |=> (r_state == S_IDLE))
        else $error("row end did not return to idle");

    a_group_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !r_oor) |-> ((r_rs < sg_eff) && (r_rz < zg_eff)))
        else $error("group remainder out of range");

endmodule
`default_nettype wire

### rtl/core/dgr_div.sv
// restoring divider, one quotient bit per cycle
// depends on dgr_pkg
`default_nettype none
module dgr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dgr_pkg::t_div_req i_req,
    output dgr_pkg::t_div_st  o_st
);
    import dgr_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } t_dstate;

    t_dstate          r_state;
    logic [NUM_W-1:0] r_dvd;
    logic [AX_W-1:0]  r_dvs;
    logic [AX_W-1:0]  r_rem;
    logic [GI_W-1:0]  r_quot;
    logic [5:0]       r_cnt;
    logic [AX_W:0]    trial;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_dvd[NUM_W-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE, D_DONE: begin
                    if (i_req.start) begin
                        r_dvd   <= i_req.dividend;
                        r_dvs   <= i_req.divisor;
                        r_rem   <= '0;
                        r_quot  <= '0;
                        r_cnt   <= 6'(NUM_W - 1);
                        r_state <= D_RUN;
                    end else begin
                        r_state <= D_IDLE;
                    end
                end
                D_RUN: begin
                    r_rem  <= fits ? AX_W'(trial - {1'b0, r_dvs}) : trial[AX_W-1:0];
                    r_quot <= {r_quot[GI_W-2:0], fits};
                    r_dvd  <= r_dvd << 1;
                    if (r_cnt == 6'd0) begin
                        r_state <= D_DONE;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_comb begin
        o_st.ready = (r_state == D_IDLE) || (r_state == D_DONE);
        o_st.done  = (r_state == D_DONE);
        o_st.quot  = r_quot;
        o_st.rem   = r_rem;
    end

endmodule
`default_nettype wire

### rtl/core/dgr_fpu.sv
// shared single precision subtract / multiply unit, takes a new op only when idle or done
// depends on dgr_pkg
`default_nettype none
module dgr_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dgr_pkg::t_fpu_req i_req,
    output dgr_pkg::t_fpu_st  o_st
);
    import dgr_pkg::*;

    typedef enum logic [7:0] {
        F_IDLE   = 8'b0000_0001,
        F_PREP   = 8'b0000_0010,
        F_ADD    = 8'b0000_0100,
        F_MUL    = 8'b0000_1000,
        F_NORM   = 8'b0001_0000,
        F_DENORM = 8'b0010_0000,
        F_ROUND  = 8'b0100_0000,
        F_DONE   = 8'b1000_0000
    } t_fstate;

    function automatic logic [5:0] lzc48(input logic [47:0] m);
        logic [5:0] z;
        z = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) z = 6'(47 - i);
        end
        return z;
    endfunction

    t_fstate            r_state;
    t_fop               r_op;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [47:0]        r_ma;
    logic [47:0]        r_mb;
    logic [47:0]        r_m;
    logic signed [11:0] r_e;
    logic               r_sign;
    logic               r_sub;
    logic               r_st;
    logic [31:0]        r_res;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
    logic [23:0] ma, mb, mbig, msml;
    logic [7:0]  ea, eb, ebig, esml, diff;
    logic        bs, a_big, sbig, ssml;
    logic [47:0] sml48, sml_sh;
    logic        lost;
    logic        special;
    logic [31:0] spec_res;
    logic [5:0]  lz;
    logic signed [11:0] sh_s;
    logic [5:0]  sh6;
    logic        sh_all;
    logic [23:0] mant;
    logic        up;

    always_comb begin
        a_nan  = (r_a[30:23] == 8'hFF) && (r_a[22:0] != 23'd0);
        b_nan  = (r_b[30:23] == 8'hFF) && (r_b[22:0] != 23'd0);
        a_inf  = (r_a[30:0] == F32_INF);
        b_inf  = (r_b[30:0] == F32_INF);
        a_zero = (r_a[30:0] == 31'd0);
        b_zero = (r_b[30:0] == 31'd0);
        sx     = r_a[31] ^ r_b[31];
        ma     = {r_a[30:23] != 8'd0, r_a[22:0]};
        mb     = {r_b[30:23] != 8'd0, r_b[22:0]};
        ea     = (r_a[30:23] == 8'd0) ? 8'd1 : r_a[30:23];
        eb     = (r_b[30:23] == 8'd0) ? 8'd1 : r_b[30:23];
        bs     = ~r_b[31];
        a_big  = r_a[30:0] >= r_b[30:0];
        mbig   = a_big ? ma : mb;
        msml   = a_big ? mb : ma;
        ebig   = a_big ? ea : eb;
        esml   = a_big ? eb : ea;
        sbig   = a_big ? r_a[31] : bs;
        ssml   = a_big ? bs : r_a[31];
        diff   = ebig - esml;
        sml48  = {1'b0, msml, 23'd0};
        if (diff >= 8'd48) begin
            sml_sh = 48'd0;
            lost   = |sml48;
        end else begin
            sml_sh = sml48 >> diff;
            lost   = |(sml48 & ((48'd1 << diff) - 48'd1));
        end

        special  = 1'b1;
        spec_res = 32'd0;
        if (r_op == FOP_SUB) begin
            if (a_nan)                 spec_res = r_a | F32_QBIT;
            else if (b_nan)            spec_res = r_b | F32_QBIT;
            else if (a_inf && b_inf)   spec_res = (r_a[31] == r_b[31]) ? F32_DNAN : r_a;
            else if (a_inf)            spec_res = r_a;
            else if (b_inf)            spec_res = {bs, r_b[30:0]};
            else                       special  = 1'b0;
        end else begin
            if (a_nan)                 spec_res = r_a | F32_QBIT;
            else if (b_nan)            spec_res = r_b | F32_QBIT;
            else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = F32_DNAN;
            else if (a_inf || b_inf)   spec_res = {sx, F32_INF};
            else if (a_zero || b_zero) spec_res = {sx, 31'd0};
            else                       special  = 1'b0;
        end

        lz     = lzc48(r_m);
        sh_s   = 12'sd1 - r_e;
        sh_all = sh_s >= 12'sd48;
        sh6    = sh_s[5:0];
        mant   = r_m[47:24];
        up     = r_m[23] & ((|r_m[22:0]) | r_st | mant[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE, F_DONE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_state <= F_PREP;
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_PREP: begin
                    r_st <= 1'b0;
                    if (special) begin
                        r_res   <= spec_res;
                        r_state <= F_DONE;
                    end else if (r_op == FOP_SUB) begin
                        r_ma    <= {1'b0, mbig, 23'd0};
                        r_mb    <= {sml_sh[47:1], sml_sh[0] | lost};
                        r_sub   <= sbig != ssml;
                        r_sign  <= sbig;
                        r_e     <= $signed({4'd0, ebig}) + 12'sd1;
                        r_state <= F_ADD;
                    end else begin
                        r_ma    <= {24'd0, ma};
                        r_mb    <= {24'd0, mb};
                        r_sign  <= sx;
                        r_e     <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
                        r_state <= F_MUL;
                    end
                end
                F_ADD: begin
                    r_m     <= r_sub ? r_ma - r_mb : r_ma + r_mb;
                    r_state <= F_NORM;
                end
                F_MUL: begin
                    r_m     <= r_ma[23:0] * r_mb[23:0];
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    if (r_m == 48'd0) begin
                        r_res   <= 32'd0;
                        r_state <= F_DONE;
                    end else begin
                        r_m     <= r_m << lz;
                        r_e     <= r_e - $signed({6'd0, lz});
                        r_state <= F_DENORM;
                    end
                end
                F_DENORM: begin
                    if (r_e >= 12'sd255) begin
                        r_res   <= {r_sign, F32_INF};
                        r_state <= F_DONE;
                    end else begin
                        if (r_e < 12'sd1) begin
                            r_e <= 12'sd0;
                            if (sh_all) begin
                                r_m  <= 48'd0;
                                r_st <= r_st | (|r_m);
                            end else begin
                                r_m  <= r_m >> sh6;
                                r_st <= r_st | (|(r_m & ((48'd1 << sh6) - 48'd1)));
                            end
                        end
                        r_state <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    r_res   <= {r_sign, {r_e[7:0], mant[22:0]} + {30'd0, up}};
                    r_state <= F_DONE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        o_st.ready = (r_state == F_IDLE) || (r_state == F_DONE);
        o_st.done  = (r_state == F_DONE);
        o_st.res   = r_res;
    end

endmodule
`default_nettype wire

### rtl/core/dgr_store.sv
// weight byte store and the scale / zero point tables, registered reads
// depends on dgr_pkg
`default_nettype none
module dgr_store (
    input  logic             i_clk,
    input  dgr_pkg::t_st_wr  i_wr,
    input  dgr_pkg::t_st_rd  i_rd,
    output logic [7:0]       o_byte,
    output logic [31:0]      o_scale,
    output logic [31:0]      o_zero
);
    import dgr_pkg::*;

    logic [7:0]  weights [STORE_BYTES];
    logic [31:0] scales  [GROUP_ENTRIES];
    logic [31:0] zeros   [GROUP_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.data_we) begin
            weights[i_wr.addr] <= i_wr.wdata[7:0];
        end
        if (i_rd.re) begin
            o_byte <= weights[i_rd.byte_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.scale_we) begin
            scales[i_wr.addr[GI_W-1:0]] <= i_wr.wdata;
        end
        if (i_rd.re) begin
            o_scale <= scales[i_rd.s_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.zero_we) begin
            zeros[i_wr.addr[GI_W-1:0]] <= i_wr.wdata;
        end
        if (i_rd.re) begin
            o_zero <= zeros[i_rd.z_idx];
        end
    end

endmodule
`default_nettype wire

### tb/dgr_row_checker.sv
// row checker for dequant_gather_rows: mirrors the stores and config, predicts each row
// depends on dgr_pkg for mode, format and config register codes
`timescale 1ns / 100ps
module dgr_row_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_addr,
    input  logic [31:0]        i_wdata,
    input  logic [15:0]        i_outer_row,
    input  logic signed [31:0] i_gather_index,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_value,
    input  logic               i_out_of_range,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import dgr_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        oor;
        logic        last;
    } t_elem;

    t_elem       row_q[$];
    logic [7:0]  weight_mem [STORE_BYTES];
    logic [31:0] scale_mem [GROUP_ENTRIES];
    logic [31:0] zero_mem [GROUP_ENTRIES];

    logic [1:0] fmt;
    logic       half_out;
    logic       use_zp;
    logic       wrap_neg;
    int         axis_len;
    int         row_len;
    int         sgroup;
    int         zgroup;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        for (int i = 0; i < STORE_BYTES; i++) weight_mem[i] = 8'd0;
        for (int i = 0; i < GROUP_ENTRIES; i++) begin
            scale_mem[i] = 32'd0;
            zero_mem[i] = 32'd0;
        end
    end

    function automatic real f32_value(logic [31:0] b);
        int  ex;
        real mag;
        ex = int'(b[30:23]);
        if (ex == 0) mag = real'(b[22:0]) * 2.0 ** (-149);
        else mag = real'({1'b1, b[22:0]}) * 2.0 ** (ex - 150);
        return b[31] ? -mag : mag;
    endfunction

    // round a double to f32 bits, nearest even
    function automatic logic [31:0] round_f32(real x);
        logic [63:0] d;
        logic [63:0] full;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] halfw;
        logic [31:0] r;
        int          e;
        int          sh;
        d = $realtobits(x);
        if (d[62:0] == 63'd0) return {d[63], 31'd0};
        e = int'(d[62:52]) - 1023;
        if (e > 127) return {d[63], 31'h7F80_0000};
        full = {11'd0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) return {d[63], 31'd0};
        keep = full >> sh;
        rem = full & ((64'd1 << sh) - 64'd1);
        halfw = 64'd1 << (sh - 1);
        if (rem > halfw || (rem == halfw && keep[0])) keep = keep + 64'd1;
        if (e >= -126) r = 32'((e + 126) << 23) + keep[31:0];
        else r = keep[31:0];
        if (r[30:0] >= 31'h7F80_0000) r = 32'h7F80_0000;
        return {d[63], r[30:0]};
    endfunction

    function automatic logic [31:0] narrow_f16(logic [31:0] x);
        logic [15:0] sgn;
        int          ex;
        int          e;
        int          man;
        int          full;
        int          sh;
        int          rem;
        int          halfw;
        int          h;
        sgn = {x[31], 15'd0};
        ex = int'(x[30:23]);
        man = int'(x[22:0]);
        e = ex - 112;
        if (ex == 255) begin
            if (man != 0) return {16'd0, sgn | 16'h7E00 | 16'(man >> 13)};
            return {16'd0, sgn | 16'h7C00};
        end
        if (e >= 31) return {16'd0, sgn | 16'h7C00};
        if (e <= 0) begin
            if (e < -10) return {16'd0, sgn};
            full = man | 32'h0080_0000;
            sh = 14 - e;
            rem = full & ((1 << sh) - 1);
            halfw = 1 << (sh - 1);
            h = full >> sh;
            if (rem > halfw || (rem == halfw && h[0])) h++;
            return {16'd0, sgn | 16'(h)};
        end
        h = (e << 10) | (man >> 13);
        rem = man & 32'h1FFF;
        if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
        return {16'd0, sgn | 16'(h)};
    endfunction

    function automatic int unpack_code(longint unsigned num);
        logic [7:0] b;
        logic [3:0] nib;
        if (fmt == FMT_U8 || fmt == FMT_I8) begin
            b = weight_mem[num % STORE_BYTES];
            if (fmt == FMT_I8 && b[7]) return int'(b) - 256;
            return int'(b);
        end
        b = weight_mem[(num >> 1) % STORE_BYTES];
        nib = num[0] ? b[7:4] : b[3:0];
        if (fmt == FMT_I4 && nib[3]) return int'(nib) - 16;
        return int'(nib);
    endfunction

    task automatic predict_row(logic [15:0] orow, logic signed [31:0] gidx);
        longint          idx;
        longint unsigned base;
        longint unsigned num;
        int              n;
        int              sg;
        int              zg;
        logic            oor;
        logic [31:0]     d;
        logic [31:0]     v;
        real             zp;
        t_elem           el;
        n = (row_len == 0) ? 1 : (row_len > MAX_ROW) ? MAX_ROW : row_len;
        sg = (sgroup == 0) ? 1 : sgroup;
        zg = (zgroup == 0) ? 1 : zgroup;
        idx = longint'(gidx);
        if (idx < 0 && wrap_neg) idx += axis_len;
        oor = (idx < 0) || (idx >= axis_len);
        base = oor ? 0 : (longint'(orow) * axis_len + idx) * n;
        for (int e = 0; e < n; e++) begin
            v = 32'd0;
            if (!oor) begin
                num = base + e;
                zp = use_zp ? f32_value(zero_mem[(num / zg) % GROUP_ENTRIES]) : 0.0;
                d = round_f32(real'(unpack_code(num)) - zp);
                v = round_f32(f32_value(d) * f32_value(scale_mem[(num / sg) % GROUP_ENTRIES]));
                if (half_out) v = narrow_f16(v);
            end
            el.value = v;
            el.oor = oor;
            el.last = (e + 1 == n);
            row_q.push_back(el);
        end
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on %s, got %h, want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_elem want;
        if (!i_rst_n) begin
            fmt = FMT_U8;
            half_out = 1'b0;
            use_zp = 1'b0;
            wrap_neg = 1'b0;
            axis_len = 1;
            row_len = 1;
            sgroup = 1;
            zgroup = 1;
            row_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FORMAT: fmt = i_cfg_data[1:0];
                    CFG_HALF:   half_out = i_cfg_data[0];
                    CFG_USE_ZP: use_zp = i_cfg_data[0];
                    CFG_WRAP:   wrap_neg = i_cfg_data[0];
                    CFG_AXIS:   axis_len = int'(i_cfg_data);
                    CFG_ROWLEN: row_len = int'(i_cfg_data[6:0]);
                    CFG_SGROUP: sgroup = int'(i_cfg_data);
                    CFG_ZGROUP: zgroup = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_DATA:  weight_mem[i_addr] = i_wdata[7:0];
                    MODE_SCALE: scale_mem[i_addr % GROUP_ENTRIES] = i_wdata;
                    MODE_ZERO:  zero_mem[i_addr % GROUP_ENTRIES] = i_wdata;
                    default:    predict_row(i_outer_row, i_gather_index);
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (row_q.size() == 0) begin
                    flag_mismatch("beat with no row pending", i_value, 32'd0);
                end else begin
                    want = row_q.pop_front();
                    if (i_value !== want.value) flag_mismatch("value", i_value, want.value);
                    if (i_out_of_range !== want.oor)
                        flag_mismatch("out_of_range", 32'(i_out_of_range), 32'(want.oor));
                    if (i_last !== want.last)
                        flag_mismatch("last", 32'(i_last), 32'(want.last));
                end
            end
        end
        o_pending = row_q.size();
    end

endmodule

### tb/dequant_gather_rows_test.sv
// top of the dequant_gather_rows testbench: clock, reset, stimulus and verdict
// depends on dgr_pkg, the dequant_gather_rows rtl and dgr_row_checker
`timescale 1ns / 100ps
module dequant_gather_rows_test;
    import dgr_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_mode = MODE_DATA;
    logic [15:0]        i_addr = 16'd0;
    logic [31:0]        i_wdata = 32'd0;
    logic [15:0]        i_outer_row = 16'd0;
    logic signed [31:0] i_gather_index = 32'sd0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [31:0]        o_value;
    logic               o_out_of_range;
    logic               o_last;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = CFG_FORMAT;
    logic [16:0]        i_cfg_data = 17'd0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    int hold_go = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items = 0;

    bit data_ok [STORE_BYTES];
    bit scale_ok [GROUP_ENTRIES];
    bit zero_ok [GROUP_ENTRIES];

    int fmt_s = 0;
    int zp_s = 0;
    int wrap_s = 0;
    int axis_s = 1;
    int rlen_s = 1;
    int sg_s = 1;
    int zg_s = 1;

    dequant_gather_rows dut (.*);

    dgr_row_checker gather_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_mode(i_mode), .i_addr(i_addr), .i_wdata(i_wdata),
        .i_outer_row(i_outer_row), .i_gather_index(i_gather_index),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_value(o_value), .i_out_of_range(o_out_of_range), .i_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // output side stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_scale();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return {1'($urandom_range(1)), 31'd0};
        if (pick == 1) return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
        if (pick == 2) return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
        return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endfunction

    // zero points stay in a range where the subtract is exact in double
    function automatic logic [31:0] rand_zero();
        if ($urandom_range(7) == 0) return 32'd0;
        return {1'($urandom), 8'($urandom_range(115, 140)), 23'($urandom)};
    endfunction

    task automatic put_beat(logic [1:0] mode, logic [15:0] addr, logic [31:0] wdata,
                            logic [15:0] orow, logic [31:0] gidx);
        if (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_addr <= addr;
        i_wdata <= wdata;
        i_outer_row <= orow;
        i_gather_index <= gidx;
        do @(posedge i_clk); while (o_in_stall);
        items++;
        case (mode)
            MODE_DATA:  data_ok[addr] = 1'b1;
            MODE_SCALE: scale_ok[addr % GROUP_ENTRIES] = 1'b1;
            MODE_ZERO:  zero_ok[addr % GROUP_ENTRIES] = 1'b1;
            default: ;
        endcase
    endtask

    // load any store byte or table entry the row would read before it was written
    task automatic gather(logic [15:0] orow, logic [31:0] gidx);
        longint          idx;
        longint unsigned base;
        longint unsigned num;
        int              n;
        int              a;
        int              si;
        n = (rlen_s == 0) ? 1 : (rlen_s > MAX_ROW) ? MAX_ROW : rlen_s;
        idx = longint'(signed'(gidx));
        if (idx < 0 && wrap_s != 0) idx += axis_s;
        if (idx >= 0 && idx < axis_s) begin
            base = (longint'(orow) * axis_s + idx) * n;
            for (int e = 0; e < n; e++) begin
                num = base + e;
                a = (fmt_s == FMT_U4 || fmt_s == FMT_I4) ? int'((num >> 1) % STORE_BYTES)
                                                         : int'(num % STORE_BYTES);
                if (!data_ok[a])
                    put_beat(MODE_DATA, 16'(a), $urandom, 16'($urandom), $urandom);
                si = int'((num / ((sg_s == 0) ? 1 : sg_s)) % GROUP_ENTRIES);
                if (!scale_ok[si])
                    put_beat(MODE_SCALE, 16'(si), rand_scale(), 16'($urandom), $urandom);
                si = int'((num / ((zg_s == 0) ? 1 : zg_s)) % GROUP_ENTRIES);
                if (zp_s != 0 && !zero_ok[si])
                    put_beat(MODE_ZERO, 16'(si), rand_zero(), 16'($urandom), $urandom);
            end
        end
        put_beat(MODE_GATHER, 16'($urandom), $urandom, orow, gidx);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apply_config(int fmt, int half, int zp, int wrap, int axis, int rlen,
                                int sg, int zg);
        int vals [8];
        vals = '{fmt, half, zp, wrap, axis, rlen, sg, zg};
        for (int r = 0; r < 8; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data <= 17'(vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        fmt_s = fmt & 3;
        zp_s = zp & 1;
        wrap_s = wrap & 1;
        axis_s = axis & 32'h1FFFF;
        rlen_s = rlen & 32'h7F;
        sg_s = sg & 32'h1FFFF;
        zg_s = zg & 32'h1FFFF;
    endtask

    function automatic int rand_size(int top);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 0;
        if (pick == 1) return top;
        if (pick == 2) return $urandom_range(0, 131071);
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int         phase;
        int         span;
        int         pick;
        int         r;
        logic [1:0] wmode;
        phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: u8, f32, no zero point, no wrap, axis length one
        put_beat(MODE_DATA, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 32'd0);
        put_beat(MODE_SCALE, 16'hFFFF, 32'h3FC0_0000, 16'hFFFF, 32'hFFFF_FFFF);
        put_beat(MODE_ZERO, 16'd0, 32'd0, 16'd0, 32'd0);
        gather(16'd0, 32'd0);
        gather(16'd0, 32'hFFFF_FFFF);
        gather(16'd0, 32'h7FFF_FFFF);
        gather(16'd0, 32'h8000_0000);
        gather(16'hFFFF, 32'd0);
        settle();

        // i4 to f16 with zero points, axis of 65536, widest row, wrapped negative index
        apply_config(FMT_I4, 1, 1, 1, 65536, 64, 0, 65536);
        gather(16'd0, 32'hFFFF_FFFF);
        gather(16'd0, 32'h8000_0000);
        gather(16'hFFFF, 32'd65535);
        settle();
        // u4 with empty axis and zero row length
        apply_config(FMT_U4, 0, 0, 1, 0, 0, 1, 1);
        gather(16'd3, 32'hFFFF_FFFF);
        gather(16'd0, 32'd0);
        settle();
        // i8 with oversize row length and scale group, zero point group of 0
        apply_config(FMT_I8, 0, 1, 1, 3, 127, 131071, 0);
        gather(16'd1, 32'd2);
        gather(16'd1, -32'sd3);
        gather(16'd2, 32'd3);
        settle();
        apply_config(FMT_U8, 1, 1, 0, 5, 4, 3, 2);
        gather(16'd0, 32'd4);
        gather(16'd1, -32'sd1);
        settle();

        while (items < 300 || phase < 4) begin
            apply_config($urandom_range(3), $urandom_range(1), $urandom_range(1),
                         $urandom_range(1), rand_size(65536), rand_size(64),
                         rand_size(65536), rand_size(65536));
            calm = (phase == 3);
            if (phase == 2) hold_go++;
            span = $urandom_range(10, 20);
            for (int k = 0; k < span; k++) begin
                if (phase == 1 && k == 5) settle();
                pick = $urandom_range(99);
                if (pick < 70) begin
                    if (axis_s == 0) r = $urandom;
                    else if (wrap_s != 0 && $urandom_range(3) == 0)
                        r = -$urandom_range(1, axis_s);
                    else r = $urandom_range(0, axis_s - 1);
                    gather(($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                           r);
                end else if (pick < 80) begin
                    gather(16'($urandom), $urandom);
                end else begin
                    wmode = 2'($urandom_range(2));
                    put_beat(wmode, 16'($urandom),
                             (wmode == MODE_SCALE) ? rand_scale() :
                             (wmode == MODE_ZERO) ? rand_zero() : $urandom,
                             16'($urandom), $urandom);
                end
            end
            settle();
            phase++;
        end

        calm = 1'b0;
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### dequant_gather_rows.f
rtl/core/dgr_pkg.sv
rtl/core/dgr_div.sv
rtl/core/dgr_fpu.sv
rtl/core/dgr_store.sv
rtl/core/dequant_gather_rows.sv
tb/dgr_row_checker.sv
tb/dequant_gather_rows_test.sv
